FILE: sv/sdfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SDF LOD snorm8 quantizer package
// Widths, level constants and configuration register indexes shared by the
// channel interfaces and the quantizer.
// ----------------------------------------------------------------------------
package sdfq_pkg;

    localparam int MAX_GRID_LOG2   = 8;
    localparam int COARSEST_WIDTH  = 8;
    localparam int COARSEST_LOG2   = $clog2(COARSEST_WIDTH);
    localparam int MAX_LEVELS      = MAX_GRID_LOG2 - COARSEST_LOG2 + 1;

    localparam int DIST_W    = 32;
    localparam int COORD_W   = 9;
    localparam int LEVEL_W   = 3;
    localparam int ADDR_W    = 25;
    localparam int CODE_W    = 8;
    localparam int GRID_W    = 4;
    localparam int SCALE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int PROD_W    = DIST_W + SCALE_W;
    localparam int FRAC_W    = 40;
    localparam int M127_W    = FRAC_W + 7;
    localparam int W1_W      = COORD_W;
    localparam int ROW_W     = 17;
    localparam int TZ_W      = 4;

    localparam logic [GRID_W-1:0] GRID_RESET  = GRID_W'(MAX_GRID_LOG2);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
    localparam logic [GRID_W-1:0] GRID_MIN    = GRID_W'(COARSEST_LOG2);
    localparam logic [GRID_W-1:0] GRID_MAX    = GRID_W'(MAX_GRID_LOG2);
    localparam logic [M127_W-1:0] ROUND_HALF  = M127_W'(1) << (FRAC_W - 1);
    localparam logic [6:0]        SNORM_MAX   = 7'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH_LOG2 = 2'd0,
        REG_FINEST_SCALE    = 2'd1
    } cfg_reg_t;

endpackage

FILE: sv/sdfq_corner_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SDF corner channel
// Valid/ready channel carrying one corner distance and its fine coordinates.
// ----------------------------------------------------------------------------
interface sdfq_corner_if;

    logic                               valid;
    logic                               ready;
    logic signed [sdfq_pkg::DIST_W-1:0] distance;
    logic [sdfq_pkg::COORD_W-1:0]       corner_x;
    logic [sdfq_pkg::COORD_W-1:0]       corner_y;
    logic [sdfq_pkg::COORD_W-1:0]       corner_z;

    modport source (output valid, output distance, output corner_x, output corner_y,
                    output corner_z, input ready);
    modport sink (input valid, input distance, input corner_x, input corner_y,
                  input corner_z, output ready);

endinterface

FILE: sv/sdfq_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SDF result channel
// Valid/ready channel carrying one quantized level entry.
// ----------------------------------------------------------------------------
interface sdfq_result_if;

    logic                               valid;
    logic                               ready;
    logic [sdfq_pkg::LEVEL_W-1:0]       level;
    logic [sdfq_pkg::ADDR_W-1:0]        address;
    logic signed [sdfq_pkg::CODE_W-1:0] code;
    logic                               last;

    modport source (output valid, output level, output address, output code,
                    output last, input ready);
    modport sink (input valid, input level, input address, input code,
                  input last, output ready);

endinterface

FILE: sv/sdf_lod_snorm8_quantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SDF LOD snorm8 quantizer
// Expands one fine-grid corner distance into one snorm8 entry per level of
// detail whose stride divides the corner, coarsest first.
//
//   channel   dir   handshake      beat
//   corner    in    valid/ready    distance, corner_x, corner_y, corner_z
//   result    out   valid/ready    level, address, code, last
//   cfg       in    cfg_we         cfg_index, cfg_data
//
// A level sequencer issues one level per cycle, while the issue stage can
// accept it, into a four-stage pipeline (issue, multiply, scale/address,
// round). The sequencer holds an item until its last level is issued; a
// corner outside the grid is dropped without issuing any level.
// Reset restores the register defaults and empties every stage.
// Back-pressure moves stage by stage through ready; a stalled beat holds.
// ----------------------------------------------------------------------------
module sdf_lod_snorm8_quantizer (
    input  logic                                clk,
    input  logic                                rst_n,
    sdfq_corner_if.sink                         corner,
    sdfq_result_if.source                       result,
    input  logic                                cfg_we,
    input  logic [sdfq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdfq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LW = sdfq_pkg::LEVEL_W;
    localparam int CW = sdfq_pkg::COORD_W;

    logic [sdfq_pkg::GRID_W-1:0]  grid_reg;
    logic [sdfq_pkg::SCALE_W-1:0] scale_reg;

    // level sequencer
    logic                        item_valid_reg, item_valid_next;
    logic [LW-1:0]               lod_reg, lod_next;
    logic [LW-1:0]               top_reg;
    logic                        neg_reg;
    logic [sdfq_pkg::DIST_W-1:0] mag_reg;
    logic [CW-1:0]               x_reg, y_reg, z_reg;

    // stage 1: issue
    logic                         s1_valid_reg;
    logic [LW-1:0]                s1_lod_reg;
    logic                         s1_last_reg, s1_neg_reg;
    logic [sdfq_pkg::DIST_W-1:0]  s1_mag_reg;
    logic [sdfq_pkg::SCALE_W-1:0] s1_scale_reg;
    logic [CW-1:0]                s1_x_reg, s1_y_reg, s1_z_reg;
    logic [sdfq_pkg::W1_W-1:0]    s1_w1_reg;

    // stage 2: multiply
    logic                         s2_valid_reg;
    logic [LW-1:0]                s2_lod_reg;
    logic                         s2_last_reg, s2_neg_reg;
    logic [sdfq_pkg::PROD_W-1:0]  s2_prod_reg;
    logic [sdfq_pkg::ROW_W-1:0]   s2_row_reg;
    logic [CW-1:0]                s2_x_reg;
    logic [sdfq_pkg::W1_W-1:0]    s2_w1_reg;

    // stage 3: scale by 127, address
    logic                         s3_valid_reg;
    logic [LW-1:0]                s3_lod_reg;
    logic                         s3_last_reg, s3_neg_reg, s3_sat_reg;
    logic [sdfq_pkg::M127_W-1:0]  s3_m127_reg;
    logic [sdfq_pkg::ADDR_W-1:0]  s3_addr_reg;

    // stage 4: output register
    logic                              out_valid_reg;
    logic [LW-1:0]                     out_level_reg;
    logic [sdfq_pkg::ADDR_W-1:0]       out_addr_reg;
    logic signed [sdfq_pkg::CODE_W-1:0] out_code_reg;
    logic                              out_last_reg;

    logic out_ready, s3_ready, s2_ready, s1_ready;
    logic issue, issue_end, in_accept;

    logic [sdfq_pkg::GRID_W-1:0]  g_clamp;
    logic [LW-1:0]                top_in;
    logic [CW-1:0]                width_in;
    logic                         in_range;
    logic [CW-1:0]                or_bits;
    logic [sdfq_pkg::TZ_W-1:0]    tz;
    logic [LW-1:0]                start_lod;
    logic [LW-1:0]                sh;
    logic [sdfq_pkg::M127_W-1:0]  rounded;
    logic [6:0]                   q_mag;

    assign out_ready = !out_valid_reg || result.ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign issue     = item_valid_reg && s1_ready;
    assign issue_end = issue && (lod_reg == top_reg);

    assign corner.ready = !item_valid_reg || issue_end;
    assign in_accept    = corner.valid && corner.ready;

    always_comb
    begin
        priority if (grid_reg < sdfq_pkg::GRID_MIN)
        begin
            g_clamp = sdfq_pkg::GRID_MIN;
        end
        else if (grid_reg > sdfq_pkg::GRID_MAX)
        begin
            g_clamp = sdfq_pkg::GRID_MAX;
        end
        else
        begin
            g_clamp = grid_reg;
        end
        top_in   = LW'(g_clamp - sdfq_pkg::GRID_MIN);
        width_in = CW'(1) << g_clamp;
        in_range = (corner.corner_x <= width_in) && (corner.corner_y <= width_in)
                   && (corner.corner_z <= width_in);
        or_bits  = corner.corner_x | corner.corner_y | corner.corner_z;
        tz       = '1;
        for (int i = CW - 1; i >= 0; i--)
        begin
            if (or_bits[i])
            begin
                tz = sdfq_pkg::TZ_W'(i);
            end
        end
        if (tz >= sdfq_pkg::TZ_W'(top_in))
        begin
            start_lod = '0;
        end
        else
        begin
            start_lod = top_in - LW'(tz);
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        lod_next        = lod_reg;
        if (in_accept)
        begin
            item_valid_next = in_range;
            lod_next        = start_lod;
        end
        else if (issue_end)
        begin
            item_valid_next = 1'b0;
        end
        else if (issue)
        begin
            lod_next = lod_reg + LW'(1);
        end
    end

    assign sh = top_reg - lod_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg  <= sdfq_pkg::GRID_RESET;
            scale_reg <= sdfq_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sdfq_pkg::REG_GRID_WIDTH_LOG2:
                begin
                    grid_reg <= cfg_data[sdfq_pkg::GRID_W-1:0];
                end
                sdfq_pkg::REG_FINEST_SCALE:
                begin
                    scale_reg <= cfg_data[sdfq_pkg::SCALE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            lod_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            lod_reg        <= lod_next;
            if (s1_ready)
            begin
                s1_valid_reg <= issue;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    assign rounded = s3_m127_reg + sdfq_pkg::ROUND_HALF;
    assign q_mag   = s3_sat_reg ? sdfq_pkg::SNORM_MAX
                                : rounded[sdfq_pkg::M127_W-1:sdfq_pkg::FRAC_W];

    // payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            top_reg <= top_in;
            neg_reg <= corner.distance[sdfq_pkg::DIST_W-1];
            mag_reg <= corner.distance[sdfq_pkg::DIST_W-1]
                       ? (~corner.distance + sdfq_pkg::DIST_W'(1))
                       : corner.distance;
            x_reg   <= corner.corner_x;
            y_reg   <= corner.corner_y;
            z_reg   <= corner.corner_z;
        end
        if (issue)
        begin
            s1_lod_reg   <= lod_reg;
            s1_last_reg  <= (lod_reg == top_reg);
            s1_neg_reg   <= neg_reg;
            s1_mag_reg   <= mag_reg;
            s1_scale_reg <= scale_reg >> sh;
            s1_x_reg     <= x_reg >> sh;
            s1_y_reg     <= y_reg >> sh;
            s1_z_reg     <= z_reg >> sh;
            s1_w1_reg    <= (sdfq_pkg::W1_W'(sdfq_pkg::COARSEST_WIDTH) << lod_reg)
                            + sdfq_pkg::W1_W'(1);
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_lod_reg  <= s1_lod_reg;
            s2_last_reg <= s1_last_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_prod_reg <= sdfq_pkg::PROD_W'(s1_mag_reg) * sdfq_pkg::PROD_W'(s1_scale_reg);
            s2_row_reg  <= sdfq_pkg::ROW_W'(s1_y_reg)
                           + sdfq_pkg::ROW_W'(s1_w1_reg) * sdfq_pkg::ROW_W'(s1_z_reg);
            s2_x_reg    <= s1_x_reg;
            s2_w1_reg   <= s1_w1_reg;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_lod_reg  <= s2_lod_reg;
            s3_last_reg <= s2_last_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_sat_reg  <= |s2_prod_reg[sdfq_pkg::PROD_W-1:sdfq_pkg::FRAC_W];
            s3_m127_reg <= {s2_prod_reg[sdfq_pkg::FRAC_W-1:0], 7'b0}
                           - {7'b0, s2_prod_reg[sdfq_pkg::FRAC_W-1:0]};
            s3_addr_reg <= sdfq_pkg::ADDR_W'(s2_x_reg)
                           + sdfq_pkg::ADDR_W'(s2_w1_reg) * sdfq_pkg::ADDR_W'(s2_row_reg);
        end
        if (s3_valid_reg && out_ready)
        begin
            out_level_reg <= s3_lod_reg;
            out_addr_reg  <= s3_addr_reg;
            out_last_reg  <= s3_last_reg;
            out_code_reg  <= s3_neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.level   = out_level_reg;
    assign result.address = out_addr_reg;
    assign result.code    = out_code_reg;
    assign result.last    = out_last_reg;

    a_code_range : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.code != -8'sd128)
        else $error("code outside snorm8 range");

    a_lod_bound : assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> lod_reg <= top_reg)
        else $error("level sequencer past last level");

    a_drop_outside : assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !in_range |=> !item_valid_reg)
        else $error("corner outside grid not dropped");

    a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_lod_reg))
        else $error("stalled issue stage lost its beat");

    a_last_level : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg |-> s1_scale_reg == scale_reg)
        else $error("final level not at finest scale");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SDF LOD snorm8 quantizer testbench
// Drives corner beats with random gaps and result back-pressure, and steps
// through several grid width and scale settings, extremes included. Each
// accepted corner is expanded into its expected per-level entries, and every
// result beat is compared field by field against the oldest pending entry.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [sdfq_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 80;
    localparam int SETTLE      = 10;

    typedef struct packed {
        logic [sdfq_pkg::LEVEL_W-1:0] level;
        logic [sdfq_pkg::ADDR_W-1:0]  address;
        logic [sdfq_pkg::CODE_W-1:0]  code;
        logic                         last;
    } lod_entry_t;

    class lod_entry_predictor;
        logic [sdfq_pkg::GRID_W-1:0]  grid_log2;
        logic [sdfq_pkg::SCALE_W-1:0] finest_scale;
        lod_entry_t                   pending_entries[$];
        int                           mismatch_count;

        function new();
            grid_log2      = sdfq_pkg::GRID_RESET;
            finest_scale   = sdfq_pkg::SCALE_RESET;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [sdfq_pkg::CFG_IDX_W-1:0] idx,
                                logic [sdfq_pkg::CFG_DATA_W-1:0] data);
            if (idx == sdfq_pkg::REG_GRID_WIDTH_LOG2)
                grid_log2 = data[sdfq_pkg::GRID_W-1:0];
            else if (idx == sdfq_pkg::REG_FINEST_SCALE)
                finest_scale = data[sdfq_pkg::SCALE_W-1:0];
        endfunction

        function int unsigned active_log2();
            if (grid_log2 < sdfq_pkg::GRID_MIN)
                return sdfq_pkg::COARSEST_LOG2;
            if (grid_log2 > sdfq_pkg::GRID_MAX)
                return sdfq_pkg::MAX_GRID_LOG2;
            return grid_log2;
        endfunction

        function logic [sdfq_pkg::CODE_W-1:0] snorm_code(
                logic [sdfq_pkg::DIST_W-1:0] dist_bits,
                logic [sdfq_pkg::SCALE_W-1:0] scale);
            logic [32:0] mag;
            logic [63:0] prod;
            logic [63:0] q;
            mag  = dist_bits[sdfq_pkg::DIST_W-1] ? (33'h1_0000_0000 - {1'b0, dist_bits})
                                                 : {1'b0, dist_bits};
            prod = 64'(mag) * 64'(scale);
            if (prod >= (64'd1 << sdfq_pkg::FRAC_W))
                q = 64'd127;
            else
                q = (prod * 64'd127 + (64'd1 << (sdfq_pkg::FRAC_W - 1))) >> sdfq_pkg::FRAC_W;
            return dist_bits[sdfq_pkg::DIST_W-1] ? 8'(-q[7:0]) : q[7:0];
        endfunction

        function void note_corner(logic [sdfq_pkg::DIST_W-1:0] dist_bits,
                                  logic [sdfq_pkg::COORD_W-1:0] x,
                                  logic [sdfq_pkg::COORD_W-1:0] y,
                                  logic [sdfq_pkg::COORD_W-1:0] z);
            int unsigned     g;
            int unsigned     levels;
            int unsigned     sh;
            longint unsigned span;
            longint unsigned mask;
            longint unsigned w1;
            longint unsigned addr;
            lod_entry_t      e;
            int              hits;
            g      = active_log2();
            levels = g - sdfq_pkg::COARSEST_LOG2 + 1;
            span   = 64'd1 << g;
            hits   = 0;
            if (x > span || y > span || z > span)
                return;
            for (int lod = 0; lod < levels; lod++)
            begin
                sh   = levels - 1 - lod;
                mask = (64'd1 << sh) - 1;
                if (((x & mask) | (y & mask) | (z & mask)) != 0)
                    continue;
                w1        = (64'(sdfq_pkg::COARSEST_WIDTH) << lod) + 1;
                addr      = (x >> sh) + w1 * ((y >> sh) + w1 * (z >> sh));
                e.level   = sdfq_pkg::LEVEL_W'(lod);
                e.address = addr[sdfq_pkg::ADDR_W-1:0];
                e.code    = snorm_code(dist_bits, finest_scale >> sh);
                e.last    = 1'b0;
                pending_entries.push_back(e);
                hits++;
            end
            if (hits > 0)
                pending_entries[pending_entries.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("error at %0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_entry(lod_entry_t got);
            lod_entry_t want;
            if (pending_entries.size() == 0)
            begin
                report_mismatch("result beat with no entry pending");
                return;
            end
            want = pending_entries.pop_front();
            if (got.level !== want.level)
                report_mismatch($sformatf("level got %0d want %0d", got.level, want.level));
            if (got.address !== want.address)
                report_mismatch($sformatf("address got %0d want %0d (level %0d)",
                                          got.address, want.address, want.level));
            if (got.code !== want.code)
                report_mismatch($sformatf("code got %0d want %0d (level %0d)",
                                          $signed(got.code), $signed(want.code), want.level));
            if (got.last !== want.last)
                report_mismatch($sformatf("last got %0b want %0b (level %0d)",
                                          got.last, want.last, want.level));
        endtask

        task flush_pending();
            if (pending_entries.size() != 0)
                report_mismatch($sformatf("%0d entries never arrived", pending_entries.size()));
        endtask
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [sdfq_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sdfq_pkg::CFG_DATA_W-1:0] cfg_data;

    sdfq_corner_if corner_ch ();
    sdfq_result_if result_ch ();

    lod_entry_predictor predictor = new();

    bit hold_sink;
    bit no_idling;
    int quiet_cycles;

    sdf_lod_snorm8_quantizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .corner    (corner_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                predictor.write_reg(cfg_index, cfg_data);
            if (corner_ch.valid && corner_ch.ready)
                predictor.note_corner(corner_ch.distance, corner_ch.corner_x,
                                      corner_ch.corner_y, corner_ch.corner_z);
            if (result_ch.valid && result_ch.ready)
                predictor.check_entry(lod_entry_t'{result_ch.level, result_ch.address,
                                                   result_ch.code, result_ch.last});
            if (cfg_we || (corner_ch.valid && corner_ch.ready)
                || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                result_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_sink = 1'b0;
            end
            else if (!no_idling && $urandom_range(0, 4) == 0)
            begin
                result_ch.ready = 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge clk);
            end
            else
                result_ch.ready = 1'b1;
        end
    end

    task cfg_write(logic [sdfq_pkg::CFG_IDX_W-1:0] idx,
                   logic [sdfq_pkg::CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task send_corner(logic [sdfq_pkg::DIST_W-1:0] dist_bits,
                     logic [sdfq_pkg::COORD_W-1:0] x,
                     logic [sdfq_pkg::COORD_W-1:0] y,
                     logic [sdfq_pkg::COORD_W-1:0] z);
        if (!no_idling && $urandom_range(0, 3) == 0)
        begin
            corner_ch.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        corner_ch.valid    = 1'b1;
        corner_ch.distance = dist_bits;
        corner_ch.corner_x = x;
        corner_ch.corner_y = y;
        corner_ch.corner_z = z;
        do
            @(posedge clk);
        while (!corner_ch.ready);
        @(negedge clk);
    endtask

    task drain_entries();
        corner_ch.valid = 1'b0;
        while (predictor.pending_entries.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function logic [sdfq_pkg::DIST_W-1:0] random_distance();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'h0100_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        endcase
    endfunction

    task run_phase(logic [sdfq_pkg::GRID_W-1:0] grid, logic [sdfq_pkg::SCALE_W-1:0] scale,
                   int items, bit squeeze, bit calm);
        int unsigned                  g;
        int unsigned                  levels;
        int unsigned                  sh;
        int unsigned                  span;
        logic [sdfq_pkg::COORD_W-1:0] x;
        logic [sdfq_pkg::COORD_W-1:0] y;
        logic [sdfq_pkg::COORD_W-1:0] z;
        cfg_write(sdfq_pkg::REG_GRID_WIDTH_LOG2, sdfq_pkg::CFG_DATA_W'(grid));
        cfg_write(sdfq_pkg::REG_FINEST_SCALE, scale);
        no_idling = calm;
        if (squeeze)
            hold_sink = 1'b1;
        repeat (items)
        begin
            g      = predictor.active_log2();
            levels = g - sdfq_pkg::COARSEST_LOG2 + 1;
            span   = 1 << g;
            if ($urandom_range(0, 99) < 8)
            begin
                x = $urandom_range(0, 511);
                y = $urandom_range(0, 511);
                z = $urandom_range(0, 511);
                case ($urandom_range(0, 2))
                    0: x = $urandom_range(span + 1, 511);
                    1: y = $urandom_range(span + 1, 511);
                    default: z = $urandom_range(span + 1, 511);
                endcase
            end
            else
            begin
                sh = $urandom_range(0, levels - 1);
                x  = sdfq_pkg::COORD_W'($urandom_range(0, span >> sh) << sh);
                y  = sdfq_pkg::COORD_W'($urandom_range(0, span >> sh) << sh);
                z  = sdfq_pkg::COORD_W'($urandom_range(0, span >> sh) << sh);
            end
            send_corner(random_distance(), x, y, z);
        end
        drain_entries();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = sdfq_pkg::REG_GRID_WIDTH_LOG2;
        cfg_data           = '0;
        corner_ch.valid    = 1'b0;
        corner_ch.distance = '0;
        corner_ch.corner_x = '0;
        corner_ch.corner_y = '0;
        corner_ch.corner_z = '0;
        hold_sink          = 1'b0;
        no_idling          = 1'b0;
        quiet_cycles       = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: finest width 256, unit scale
        send_corner(32'h0000_0000,   0,   0,   0);
        send_corner(32'h7FFF_FFFF, 256, 256, 256);
        send_corner(32'h8000_0000,   0,   0, 256);
        send_corner(32'h0100_0000,  32,  32,  32);
        send_corner(32'hFF00_0000,   1,   0,   0);
        send_corner(32'h0080_0000,   8,  16,  24);
        send_corner(32'hFF80_0000, 128,   0, 128);
        send_corner(32'h00FF_FFFF, 255, 255, 255);
        send_corner(32'h0100_0001,  64, 192,   0);
        send_corner(32'hFF00_0001,   0, 256,  96);
        send_corner(32'hFFFF_FFFF,   4,   4,   4);
        send_corner(32'h0000_0001,   2, 254, 100);
        send_corner(32'h1234_5678, 257,   0,   0);
        send_corner(32'h0040_0000,   0, 511,   0);
        send_corner(32'hFFC0_0000,   0,   0, 300);
        send_corner(32'h5555_5555, 511, 511, 511);
        send_corner(32'h0002_0000, 160, 224,  96);
        send_corner(32'hFFFE_0000, 256,   0,   0);
        drain_entries();

        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        run_phase(4'd3,  32'h0000_0000, 20, 1'b0, 1'b0);
        run_phase(4'd8,  32'hFFFF_FFFF, 40, 1'b1, 1'b0);
        run_phase(4'd0,  $urandom_range(32'h0001_0000, 32'h0010_0000), 25, 1'b0, 1'b0);
        run_phase(4'd15, 32'h0002_0000, 30, 1'b0, 1'b0);
        run_phase(4'd5,  $urandom, 25, 1'b0, 1'b0);
        run_phase(4'd6,  32'h0001_8000, 25, 1'b0, 1'b0);
        run_phase(4'd8,  32'h0001_0000, 45, 1'b0, 1'b1);

        predictor.flush_pending();
        if (predictor.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
sv/sdfq_pkg.sv
sv/sdfq_corner_if.sv
sv/sdfq_result_if.sv
sv/sdf_lod_snorm8_quantizer.sv
tb/tb.sv
